>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the shortest path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every clock edge outside reset.
`define USP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define USP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/usp_pkg.sv
// Types, codes and constants shared by the shortest path block.
package usp_pkg;

  localparam int VTX_W = 6;
  localparam int CNT_W = 7;
  localparam int HOP_W = 6;
  localparam int REQ_W = 2;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [VTX_W-1:0] edge_a;
    logic [VTX_W-1:0] edge_b;
    logic [VTX_W-1:0] source_vertex;
    logic [VTX_W-1:0] target_vertex;
  } item_t;

  typedef struct packed {
    logic             path_found;
    logic             step_valid;
    logic [VTX_W-1:0] step_from;
    logic [VTX_W-1:0] step_to;
    logic [HOP_W-1:0] hop_count;
    logic             last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_SCAN,
    ST_DRAIN,
    ST_LEVEL,
    ST_BT_RD,
    ST_BT_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_MISS,
    ST_SELF
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clear_graph;
    logic adj_rd_a;
    logic adj_rd_b;
    logic adj_wr_a;
    logic adj_wr_b;
    logic bfs_init;
    logic scan;
    logic level_step;
    logic bt_init;
    logic bt_rd;
    logic bt_wr;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic single_load;
    logic single_found;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_edge;
    logic is_query;
    logic edge_ok;
    logic query_ok;
    logic query_same;
    logic scan_last;
    logic next_empty;
    logic next_has_dst;
    logic bt_done;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/usp_ifs.sv
// Channel interfaces of the shortest path block: requests, results, configuration.
interface usp_req_if import usp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VTX_W-1:0] edge_a;
  logic [VTX_W-1:0] edge_b;
  logic [VTX_W-1:0] source_vertex;
  logic [VTX_W-1:0] target_vertex;

  modport source (output valid, req_type, edge_a, edge_b, source_vertex, target_vertex,
                  input ready);
  modport sink (input valid, req_type, edge_a, edge_b, source_vertex, target_vertex,
                output ready);
endinterface

interface usp_res_if import usp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             path_found;
  logic             step_valid;
  logic [VTX_W-1:0] step_from;
  logic [VTX_W-1:0] step_to;
  logic [HOP_W-1:0] hop_count;
  logic             last;

  modport source (output valid, path_found, step_valid, step_from, step_to, hop_count, last,
                  input ready);
  modport sink (input valid, path_found, step_valid, step_from, step_to, hop_count, last,
                output ready);
endinterface

interface usp_cfg_if import usp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

>>> rtl/usp_dpath.sv
// Datapath of the shortest path block: graph memory, search vectors, path memories.
module usp_dpath import usp_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            in_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_res
);

  localparam int NV = MAX_VERTICES;
  localparam int IW = $clog2(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_active;
  logic [NV-1:0]    vmask;
  item_t            item;
  logic [IW-1:0]    a_idx;
  logic [IW-1:0]    b_idx;
  logic [IW-1:0]    src_idx;
  logic [IW-1:0]    dst_idx;

  logic [NV-1:0]    adj_mem [NV];
  logic [NV-1:0]    row_valid;
  logic [NV-1:0]    adj_rdata;
  logic             adj_rvalid;
  logic [IW-1:0]    adj_raddr;
  logic             adj_re;
  logic [IW-1:0]    adj_waddr;
  logic [IW-1:0]    adj_wbit;
  logic             adj_we;
  logic [NV-1:0]    row_base;

  logic [NV-1:0]    hit;
  logic [NV-1:0]    reached;
  logic [NV-1:0]    frontier;
  logic [NV-1:0]    next_set;
  logic [IW-1:0]    scan_v;
  logic [IW-1:0]    proc_v;
  logic             proc_valid;
  logic [IW-1:0]    low_idx;
  logic             take;

  logic [IW-1:0]    level;
  logic [IW-1:0]    hops;
  logic [IW-1:0]    step_idx;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    pred_mem [NV];
  logic [IW-1:0]    pred_rdata;
  logic [2*IW-1:0]  step_mem [NV];
  logic [2*IW-1:0]  step_rdata;

  // Configuration and captured item.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n_active = CNT_W'(1);
    end else if (vertex_count > MAX_CNT) begin
      n_active = MAX_CNT;
    end else begin
      n_active = vertex_count;
    end
  end

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      vmask[i] = CNT_W'(i) < n_active;
    end
  end

  // Indexes are only used once checked against the active count.
  assign a_idx   = item.edge_a[IW-1:0];
  assign b_idx   = item.edge_b[IW-1:0];
  assign src_idx = item.source_vertex[IW-1:0];
  assign dst_idx = item.target_vertex[IW-1:0];

  // Adjacency memory; a row without its valid bit reads as empty.
  assign adj_re    = cmd.adj_rd_a | cmd.adj_rd_b | cmd.scan;
  assign adj_raddr = cmd.scan ? scan_v : (cmd.adj_rd_b ? b_idx : a_idx);
  assign adj_we    = cmd.adj_wr_a | cmd.adj_wr_b;
  assign adj_waddr = cmd.adj_wr_b ? b_idx : a_idx;
  assign adj_wbit  = cmd.adj_wr_b ? a_idx : b_idx;
  assign row_base  = adj_rvalid ? adj_rdata : '0;

  always_ff @(posedge clk) begin
    if (adj_re) begin
      adj_rdata <= adj_mem[adj_raddr];
    end
    if (adj_we) begin
      adj_mem[adj_waddr] <= row_base | (NV'(1) << adj_wbit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      adj_rvalid <= 1'b0;
    end else begin
      if (adj_re) begin
        adj_rvalid <= row_valid[adj_raddr];
      end
      if (cmd.clear_graph) begin
        row_valid <= '0;
      end else if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
    end
  end

  // Level scan: one vertex row per cycle against the current frontier.
  assign hit  = row_base & vmask & frontier;
  assign take = proc_valid && !reached[proc_v] && (hit != '0);

  always_comb begin
    low_idx = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (hit[i]) begin
        low_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    proc_v <= scan_v;
    if (cmd.bfs_init || cmd.level_step) begin
      scan_v <= '0;
    end else if (cmd.scan) begin
      scan_v <= scan_v + 1'b1;
    end
    if (cmd.bfs_init) begin
      reached  <= NV'(1) << src_idx;
      frontier <= NV'(1) << src_idx;
      next_set <= '0;
      level    <= '0;
    end else if (cmd.level_step) begin
      reached  <= reached | next_set;
      frontier <= next_set;
      next_set <= '0;
      level    <= level + 1'b1;
    end else if (take) begin
      next_set[proc_v] <= 1'b1;
    end
    if (take) begin
      pred_mem[proc_v] <= low_idx;
    end
  end

  // Backtrack from the target, storing path edges by position, then read them forward.
  always_ff @(posedge clk) begin
    if (cmd.bt_init) begin
      hops <= level + 1'b1;
      cur  <= dst_idx;
    end else if (cmd.bt_wr) begin
      cur <= pred_rdata;
    end
    if (cmd.bt_rd) begin
      pred_rdata <= pred_mem[cur];
    end
    if (cmd.bt_wr) begin
      step_mem[step_idx] <= {pred_rdata, cur};
    end
    if (cmd.emit_rd) begin
      step_rdata <= step_mem[step_idx];
    end
    if (cmd.bt_init) begin
      step_idx <= level;
    end else if (cmd.emit_init) begin
      step_idx <= '0;
    end else if (cmd.bt_wr) begin
      step_idx <= step_idx - 1'b1;
    end else if (cmd.emit_load) begin
      step_idx <= step_idx + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.single_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_res.path_found <= 1'b1;
      out_res.step_valid <= 1'b1;
      out_res.step_from  <= VTX_W'(step_rdata[2*IW-1:IW]);
      out_res.step_to    <= VTX_W'(step_rdata[IW-1:0]);
      out_res.hop_count  <= HOP_W'(hops);
      out_res.last       <= stat.emit_last;
    end else if (cmd.single_load) begin
      out_res.path_found <= cmd.single_found;
      out_res.step_valid <= 1'b0;
      out_res.step_from  <= '0;
      out_res.step_to    <= '0;
      out_res.hop_count  <= '0;
      out_res.last       <= 1'b1;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.is_clear     = item.req_type == REQ_CLEAR;
    stat.is_edge      = item.req_type == REQ_EDGE;
    stat.is_query     = item.req_type == REQ_QUERY;
    stat.edge_ok      = (CNT_W'(item.edge_a) < n_active) && (CNT_W'(item.edge_b) < n_active);
    stat.query_ok     = (CNT_W'(item.source_vertex) < n_active)
                        && (CNT_W'(item.target_vertex) < n_active);
    stat.query_same   = item.source_vertex == item.target_vertex;
    stat.scan_last    = CNT_W'(scan_v) == (n_active - 1'b1);
    stat.next_empty   = next_set == '0;
    stat.next_has_dst = next_set[dst_idx];
    stat.bt_done      = step_idx == '0;
    stat.emit_last    = step_idx == (hops - 1'b1);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

>>> rtl/usp_ctrl.sv
// Controller state machine of the shortest path block.
module usp_ctrl import usp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.is_clear) begin
          state_next = ST_IDLE;
        end else if (stat.is_edge) begin
          state_next = stat.edge_ok ? ST_EDGE_RD_A : ST_IDLE;
        end else if (stat.is_query) begin
          priority if (!stat.query_ok) state_next = ST_MISS;
          else if (stat.query_same)    state_next = ST_SELF;
          else                         state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE_RD_A: state_next = ST_EDGE_WR_A;
      ST_EDGE_WR_A: state_next = ST_EDGE_RD_B;
      ST_EDGE_RD_B: state_next = ST_EDGE_WR_B;
      ST_EDGE_WR_B: state_next = ST_IDLE;
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_LEVEL;
      ST_LEVEL: begin
        priority if (stat.next_has_dst) state_next = ST_BT_RD;
        else if (stat.next_empty)       state_next = ST_MISS;
        else                            state_next = ST_SCAN;
      end
      ST_BT_RD: state_next = ST_BT_WR;
      ST_BT_WR: begin
        state_next = stat.bt_done ? ST_EMIT_RD : ST_BT_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (stat.out_free) state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_MISS: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_SELF: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.clear_graph = stat.is_clear;
        cmd.bfs_init    = stat.is_query && stat.query_ok && !stat.query_same;
      end
      ST_EDGE_RD_A: cmd.adj_rd_a = 1'b1;
      ST_EDGE_WR_A: cmd.adj_wr_a = 1'b1;
      ST_EDGE_RD_B: cmd.adj_rd_b = 1'b1;
      ST_EDGE_WR_B: cmd.adj_wr_b = 1'b1;
      ST_SCAN:      cmd.scan     = 1'b1;
      ST_DRAIN: begin
      end
      ST_LEVEL: begin
        cmd.bt_init    = stat.next_has_dst;
        cmd.level_step = !stat.next_has_dst && !stat.next_empty;
      end
      ST_BT_RD: cmd.bt_rd = 1'b1;
      ST_BT_WR: begin
        cmd.bt_wr     = 1'b1;
        cmd.emit_init = stat.bt_done;
      end
      ST_EMIT_RD: cmd.emit_rd   = 1'b1;
      ST_EMIT_LD: cmd.emit_load = stat.out_free;
      ST_MISS:    cmd.single_load = stat.out_free;
      ST_SELF: begin
        cmd.single_load  = stat.out_free;
        cmd.single_found = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/unit_weight_shortest_path_top.sv
// Top level of the unit-weight shortest path block: controller, datapath and ports.
//
//   channel  dir  transaction carries
//   req      in   req_type, edge_a, edge_b, source_vertex, target_vertex
//   res      out  path_found, step_valid, step_from, step_to, hop_count, last
//   cfg      in   vertex_count (write only, always ready)
//
// A clear empties the graph; an edge is a read-modify-write of both rows on one port, row A then row B.
// A query scans the n active vertices one row per cycle for each level, then backtracks
// with a read and a write state a hop and emits with a read and a load state a hop.
// A lone result (no path, or target equal to source) is loaded once the output register is free.
// Reset empties the graph at once through per-row valid bits. A stalled result holds the
// block; the next request is taken once the last result of a query sits in the output register.
module unit_weight_shortest_path_top import usp_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input logic       clk,
  input logic       rst,
  usp_req_if.sink   req,
  usp_res_if.source res,
  usp_cfg_if.sink   cfg
);

  item_t   in_item;
  cmd_t    cmd;
  stat_t   stat;
  result_t out_res;
  logic    out_valid;

  // The request payload is gathered into one item; the datapath captures it on acceptance.
  assign in_item.req_type      = req.req_type;
  assign in_item.edge_a        = req.edge_a;
  assign in_item.edge_b        = req.edge_b;
  assign in_item.source_vertex = req.source_vertex;
  assign in_item.target_vertex = req.target_vertex;

  // The vertex count register takes any write at once.
  assign cfg.ready = 1'b1;

  usp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  usp_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.vertex_count),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  // The result register drives the output channel directly.
  assign res.valid      = out_valid;
  assign res.path_found = out_res.path_found;
  assign res.step_valid = out_res.step_valid;
  assign res.step_from  = out_res.step_from;
  assign res.step_to    = out_res.step_to;
  assign res.hop_count  = out_res.hop_count;
  assign res.last       = out_res.last;

endmodule

>>> rtl/usp_checker.sv
// Port-level checker of the shortest path block and its bind to the top level.
`include "assert_macros.svh"

module usp_checker import usp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_path_found,
  input logic             res_step_valid,
  input logic [VTX_W-1:0] res_step_from,
  input logic [VTX_W-1:0] res_step_to,
  input logic [HOP_W-1:0] res_hop_count,
  input logic             res_last
);

  logic                       res_stall;
  logic                       res_edge;
  logic                       res_lone;
  logic                       edge_ok;
  logic                       lone_ok;
  logic [2*VTX_W+HOP_W+2:0]   res_payload;

  assign res_stall   = res_valid && !res_ready;
  assign res_edge    = res_valid && res_step_valid;
  assign res_lone    = res_valid && !res_step_valid;
  assign edge_ok     = res_path_found && (res_hop_count != '0);
  assign lone_ok     = res_last && (res_hop_count == '0) && (res_step_from == '0)
                       && (res_step_to == '0);
  assign res_payload = {res_path_found, res_step_valid, res_step_from, res_step_to,
                        res_hop_count, res_last};

  `USP_ASSERT_NEXT(a_res_hold, clk, rst, res_stall, res_valid, "result dropped while stalled")
  `USP_ASSERT_NEXT(a_res_stable, clk, rst, res_stall, $stable(res_payload), "result moved in stall")
  `USP_ASSERT(a_step_found, clk, rst, res_edge |-> edge_ok, "path edge without a found path")
  `USP_ASSERT(a_empty_single, clk, rst, res_lone |-> lone_ok, "edgeless result is not a lone one")

endmodule

bind unit_weight_shortest_path_top usp_checker u_usp_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_path_found (res.path_found),
  .res_step_valid (res.step_valid),
  .res_step_from  (res.step_from),
  .res_step_to    (res.step_to),
  .res_hop_count  (res.hop_count),
  .res_last       (res.last)
);
